// ===== rtl/assert_macros.svh =====
// Assertion macros used by the pulse generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on clk_i, off while rst_ni is low.
`define ASSERT_ON_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication on clk_i.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/sdpg_pkg.sv =====
// Types and constants of the step/direction pulse generator.
package sdpg_pkg;

  localparam int ELAPSED_W       = 32;
  localparam int HP_W            = 32;
  localparam int CMP_W           = (ELAPSED_W > HP_W) ? ELAPSED_W : HP_W;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W         = PHASE_FRAC_BITS + 1;
  localparam int VEC_W           = 32;
  localparam int TOTAL_W         = 40;
  localparam int SUM_W           = TOTAL_W + 3;
  localparam int PM_W            = 32;
  localparam int PROD_W          = PHASE_W + TOTAL_W;
  localparam int R_W             = PROD_W - (PHASE_FRAC_BITS + 8);
  localparam int DIFF_W          = PM_W + 1;
  localparam int COUNT_W         = 24;
  localparam int KIND_W          = 3;
  localparam int SIGN_W          = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [HP_W-1:0]          HP_RESET    = HP_W'(1000);
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX  = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN  = {1'b1, {(TOTAL_W-1){1'b0}}};
  localparam logic [R_W-1:0]           TARGET_POS_MAX = R_W'({1'b0, {(PM_W-1){1'b1}}});
  localparam logic [R_W-1:0]           TARGET_NEG_MAX = R_W'({1'b1, {(PM_W-1){1'b0}}});
  localparam logic [PROD_W-1:0]        ROUND_HALF = PROD_W'(1) << (PHASE_FRAC_BITS + 7);
  localparam logic [COUNT_W-1:0]       COUNT_MAX  = {COUNT_W{1'b1}};

  localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sb00;
  localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
  localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_MOVE  = 3'd3,
    KIND_DRIVE = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_ROT_SIGN    = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/step_dir_pulse_generator.sv =====
// Step/direction pulse generator: velocity mode and move mode, one result per request.
// Takes one request per clock while not stalled and returns its result from the result register: a
// request is held in the input register, then all of its work (tick count and compare,
// move total update, or the 17 x 40 bit phase multiply with rounding and toggle count)
// runs in one combinational pass into the result register. The combinational drive-phase
// multiply sets the clock period; throughput is one request per cycle while the output is
// not stalled. Configuration writes land at once and are meant for an idle block.
`include "assert_macros.svh"

module step_dir_pulse_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sdpg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sdpg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sdpg_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [sdpg_pkg::VEC_W-1:0]    move_vector_i,
  input  logic [sdpg_pkg::PHASE_W-1:0]         phase_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 step_level_o,
  output logic                                 direction_o,
  output logic [sdpg_pkg::COUNT_W-1:0]         toggle_count_o,
  output logic signed [sdpg_pkg::SIGN_W-1:0]   step_delta_o
);
  import sdpg_pkg::*;

  logic                       in_valid_q, in_valid_d;
  logic [KIND_W-1:0]          kind_q;
  logic signed [VEC_W-1:0]    vec_q;
  logic [PHASE_W-1:0]         phase_q;

  logic                       out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SIGN_W-1:0]   delta_q, delta_d;

  logic [HP_W-1:0]            hp_q, hp_d;
  logic signed [SIGN_W-1:0]   sign_q, sign_d;
  logic                       rotating_q, rotating_d;
  logic [ELAPSED_W-1:0]       elapsed_q, elapsed_d;
  logic                       step_q, step_d;
  logic                       dir_q, dir_d;
  logic signed [TOTAL_W-1:0]  total_q, total_d;
  logic [TOTAL_W-1:0]         mag_q, mag_d;
  logic                       neg_q, neg_d;
  logic signed [PM_W-1:0]     pulses_q, pulses_d;

  logic                       adv;
  logic [ELAPSED_W-1:0]       elapsed_inc, elapsed_sub;
  logic                       tick_hit;
  logic signed [SUM_W-1:0]    move_sum;
  logic signed [TOTAL_W-1:0]  move_new;
  logic [PROD_W-1:0]          prod;
  logic [R_W-1:0]             rnd;
  logic signed [PM_W-1:0]     target;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          amt;
  logic                       amt_big;
  logic signed [SIGN_W-1:0]   cfg_sign;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // velocity tick
  assign elapsed_inc = elapsed_q + ELAPSED_W'(1);
  assign tick_hit    = CMP_W'(elapsed_inc) >= CMP_W'(hp_q);
  assign elapsed_sub = ELAPSED_W'(CMP_W'(elapsed_inc) - CMP_W'(hp_q));

  // begin move: 2*vector plus owed half-pulses, clamped to the total range
  assign move_sum = SUM_W'(total_q) - (SUM_W'(pulses_q) <<< 8) + (SUM_W'(vec_q) <<< 1);
  always_comb begin
    if (move_sum > SUM_W'(TOTAL_MAX)) begin
      move_new = TOTAL_MAX;
    end else if (move_sum < SUM_W'(TOTAL_MIN)) begin
      move_new = TOTAL_MIN;
    end else begin
      move_new = TOTAL_W'(move_sum);
    end
  end

  // drive phase: round |phase * total| away from zero
  assign prod = (PROD_W'(phase_q) * PROD_W'(mag_q)) + ROUND_HALF;
  assign rnd  = prod[PROD_W-1 -: R_W];
  always_comb begin
    if (neg_q) begin
      target = (rnd > TARGET_NEG_MAX) ? {1'b1, {(PM_W-1){1'b0}}} : PM_W'(-rnd);
    end else begin
      target = (rnd > TARGET_POS_MAX) ? {1'b0, {(PM_W-1){1'b1}}} : PM_W'(rnd);
    end
  end
  assign diff    = DIFF_W'(target) - DIFF_W'(pulses_q);
  assign amt     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign amt_big = amt > DIFF_W'(COUNT_MAX);

  always_comb begin
    unique case (cfg_data_i[SIGN_W-1:0])
      2'b00:   cfg_sign = SIGN_ZERO;
      2'b01:   cfg_sign = SIGN_POS;
      default: cfg_sign = SIGN_NEG;
    endcase
  end

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    delta_d     = delta_q;
    hp_d        = hp_q;
    sign_d      = sign_q;
    rotating_d  = rotating_q;
    elapsed_d   = elapsed_q;
    step_d      = step_q;
    dir_d       = dir_q;
    total_d     = total_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    pulses_d    = pulses_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      in_valid_d = 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end

    if (adv) begin
      out_valid_d = 1'b1;
      cnt_d       = '0;
      delta_d     = SIGN_ZERO;
      unique case (kind_q)
        KIND_TICK: begin
          if (rotating_q) begin
            if (tick_hit) begin
              elapsed_d = elapsed_sub;
              step_d    = ~step_q;
              cnt_d     = COUNT_W'(1);
              delta_d   = step_q ? SIGN_ZERO : sign_q;
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
        end
        KIND_START: begin
          rotating_d = 1'b1;
          elapsed_d  = '0;
          dir_d      = sign_q[SIGN_W-1];
        end
        KIND_STOP: begin
          rotating_d = 1'b0;
        end
        KIND_MOVE: begin
          total_d  = move_new;
          neg_d    = move_new[TOTAL_W-1];
          mag_d    = move_new[TOTAL_W-1] ? TOTAL_W'(-move_new) : TOTAL_W'(move_new);
          pulses_d = '0;
        end
        KIND_DRIVE: begin
          pulses_d = target;
          if (diff != '0) begin
            dir_d  = diff[DIFF_W-1];
            step_d = step_q ^ amt[0];
            cnt_d  = amt_big ? COUNT_MAX : amt[COUNT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_PERIOD: hp_d = cfg_data_i[HP_W-1:0];
        CFG_ROT_SIGN: begin
          sign_d = cfg_sign;
          dir_d  = cfg_sign[SIGN_W-1];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hp_q        <= HP_RESET;
      sign_q      <= SIGN_ZERO;
      rotating_q  <= 1'b0;
      elapsed_q   <= '0;
      step_q      <= 1'b0;
      dir_q       <= 1'b0;
      total_q     <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      pulses_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      hp_q        <= hp_d;
      sign_q      <= sign_d;
      rotating_q  <= rotating_d;
      elapsed_q   <= elapsed_d;
      step_q      <= step_d;
      dir_q       <= dir_d;
      total_q     <= total_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      pulses_q    <= pulses_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q  <= kind_i;
      vec_q   <= move_vector_i;
      phase_q <= phase_i;
    end
    cnt_q   <= cnt_d;
    delta_q <= delta_d;
  end

  assign out_valid_o    = out_valid_q;
  assign step_level_o   = step_q;
  assign direction_o    = dir_q;
  assign toggle_count_o = cnt_q;
  assign step_delta_o   = delta_q;

  `ASSERT_ON_CLK(a_toggle_parity, adv && !(kind_q == KIND_DRIVE && amt_big) |-> ((step_d ^ step_q) == cnt_d[0]), "step level change disagrees with toggle count parity")
  `ASSERT_IMPLIES(a_delta_rising, out_valid_o && step_delta_o != SIGN_ZERO, toggle_count_o == COUNT_W'(1) && step_level_o, "step delta without a single rising toggle")
  `ASSERT_IMPLIES(a_stall_full, in_stall_o, in_valid_q && out_valid_q && out_stall_i, "input stalled while the pipeline can move")

endmodule
